/* sv/tpp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpp_pkg
// Shared types and constants for the timer prescaler / period calculator.
// ----------------------------------------------------------------------------
package tpp_pkg;
    localparam int unsigned DVD_W = 33;
    localparam int unsigned DVS_W = 32;
    localparam int unsigned PSC_W = 16;
    localparam logic [31:0] MIN_TICKS = 32'd2;
    localparam logic [31:0] SPAN_NARROW = 32'd65536;

    typedef struct packed {
        logic             bad;
        logic             wide;
        logic [PSC_W-1:0] psc;
    } t_side;
endpackage

/* sv/tpp_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpp_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module tpp_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [tpp_pkg::DVD_W-1:0] i_dividend,
    input  logic [tpp_pkg::DVS_W-1:0] i_divisor,
    input  tpp_pkg::t_side        i_side,
    output logic                  o_valid,
    output logic [tpp_pkg::DVD_W-1:0] o_quotient,
    output tpp_pkg::t_side        o_side
);
    import tpp_pkg::*;

    logic             r_v   [DVD_W];
    logic [DVS_W-1:0] r_rem [DVD_W];
    logic [DVD_W-1:0] r_dvd [DVD_W];
    logic [DVD_W-1:0] r_q   [DVD_W];
    logic [DVS_W-1:0] r_dvs [DVD_W];
    t_side            r_sd  [DVD_W];

    genvar j;
    generate
        for (j = 0; j < DVD_W; j++) begin : g_stage
            logic             p_v;
            logic [DVS_W-1:0] p_rem;
            logic [DVD_W-1:0] p_dvd;
            logic [DVD_W-1:0] p_q;
            logic [DVS_W-1:0] p_dvs;
            t_side            p_sd;
            logic [DVS_W:0]   trial;
            logic             ge;
            logic [DVS_W:0]   diff;
            if (j == 0) begin : g_first
                assign p_v   = i_valid;
                assign p_rem = '0;
                assign p_dvd = i_dividend;
                assign p_q   = '0;
                assign p_dvs = i_divisor;
                assign p_sd  = i_side;
            end else begin : g_next
                assign p_v   = r_v[j-1];
                assign p_rem = r_rem[j-1];
                assign p_dvd = r_dvd[j-1];
                assign p_q   = r_q[j-1];
                assign p_dvs = r_dvs[j-1];
                assign p_sd  = r_sd[j-1];
            end
            assign trial = {p_rem, p_dvd[DVD_W-1]};
            assign ge    = trial >= {1'b0, p_dvs};
            assign diff  = trial - {1'b0, p_dvs};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[j] <= 1'b0;
                end else if (i_en) begin
                    r_v[j] <= p_v;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
                    r_dvd[j] <= {p_dvd[DVD_W-2:0], 1'b0};
                    r_q[j]   <= {p_q[DVD_W-2:0], ge};
                    r_dvs[j] <= p_dvs;
                    r_sd[j]  <= p_sd;
                end
            end
        end
    endgenerate

    assign o_valid    = r_v[DVD_W-1];
    assign o_quotient = r_q[DVD_W-1];
    assign o_side     = r_sd[DVD_W-1];
endmodule

/* sv/tpp_psc.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpp_psc
// Floors the tick count and picks the prescaler; registers one stage.
// ----------------------------------------------------------------------------
module tpp_psc (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [tpp_pkg::DVD_W-1:0] i_ticks_raw,
    input  tpp_pkg::t_side        i_side,
    output logic                  o_valid,
    output logic [31:0]           o_ticks,
    output logic [tpp_pkg::DVS_W-1:0] o_divisor,
    output tpp_pkg::t_side        o_side
);
    import tpp_pkg::*;

    logic             r_valid;
    logic [31:0]      r_ticks;
    t_side            r_side;
    logic [31:0]      ticks;
    logic [31:0]      tm1;
    logic [PSC_W-1:0] psc;
    t_side            n_side;

    always_comb begin
        ticks = (i_ticks_raw[31:0] < MIN_TICKS) ? MIN_TICKS : i_ticks_raw[31:0];
        tm1   = ticks - 32'd1;
        psc   = (!i_side.wide && ticks > SPAN_NARROW) ? tm1[31:16] : '0;
        n_side      = i_side;
        n_side.psc  = psc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ticks <= ticks;
            r_side  <= n_side;
        end
    end

    assign o_valid   = r_valid;
    assign o_ticks   = r_ticks;
    assign o_divisor = {16'd0, r_side.psc} + 32'd1;
    assign o_side    = r_side;
endmodule

/* sv/timer_prescaler_period_calc_top.sv */
`timescale 1ns / 1ps
// Pipeline from input beat to output beat: two 33-stage dividers, one
//   prescaler stage, one output register.
// Throughput: one beat per cycle; the whole pipeline holds while the output
//   beat is stalled.
// Reset: synchronous active-low; clears all valid bits, payload is not reset.
// ----------------------------------------------------------------------------
// timer_prescaler_period_calc_top
// Prescaler and auto-reload values from timer clock and target frequency.
// ----------------------------------------------------------------------------
module timer_prescaler_period_calc_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_clock_rate_hz,
    input  logic [31:0] i_target_freq_hz,
    input  logic        i_wide_counter,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_prescale_value,
    output logic [31:0] o_period_value,
    output logic        o_bad_request
);
    import tpp_pkg::*;

    logic             en;
    logic [DVD_W-1:0] num;
    t_side            side0;
    logic             d1_v;
    logic [DVD_W-1:0] d1_q;
    t_side            d1_sd;
    logic             p_v;
    logic [31:0]      p_ticks;
    logic [DVS_W-1:0] p_dvs;
    t_side            p_sd;
    logic             d2_v;
    logic [DVD_W-1:0] d2_q;
    t_side            d2_sd;
    logic [31:0]      per;
    logic             r_valid;
    logic [15:0]      r_psc;
    logic [31:0]      r_per;
    logic             r_bad;

    assign en      = !r_valid || i_ready;
    assign o_ready = en;

    always_comb begin
        num        = {1'b0, i_clock_rate_hz} + {2'b0, i_target_freq_hz[31:1]};
        side0.bad  = (i_target_freq_hz == 32'd0);
        side0.wide = i_wide_counter;
        side0.psc  = '0;
    end

    tpp_div u_div_ticks (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_valid),
        .i_dividend(num), .i_divisor(i_target_freq_hz), .i_side(side0),
        .o_valid(d1_v), .o_quotient(d1_q), .o_side(d1_sd)
    );

    tpp_psc u_psc (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(d1_v),
        .i_ticks_raw(d1_q), .i_side(d1_sd),
        .o_valid(p_v), .o_ticks(p_ticks), .o_divisor(p_dvs), .o_side(p_sd)
    );

    tpp_div u_div_period (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(p_v),
        .i_dividend({1'b0, p_ticks}), .i_divisor(p_dvs), .i_side(p_sd),
        .o_valid(d2_v), .o_quotient(d2_q), .o_side(d2_sd)
    );

    assign per = ((d2_q[31:0] < MIN_TICKS) ? MIN_TICKS : d2_q[31:0]) - 32'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bad <= d2_sd.bad;
            r_psc <= d2_sd.bad ? 16'd0 : d2_sd.psc;
            r_per <= d2_sd.bad ? 32'd0 : per;
        end
    end

    assign o_valid          = r_valid;
    assign o_prescale_value = r_psc;
    assign o_period_value   = r_per;
    assign o_bad_request    = r_bad;

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_request |-> o_prescale_value == 16'd0 && o_period_value == 32'd0)
        else $error("bad request with nonzero fields");
    a_per_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_bad_request |-> o_period_value != 32'd0)
        else $error("zero period on good request");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("stall with empty output");
endmodule

/* tb/timer_prescaler_period_calc_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_prescaler_period_calc_top_tb
// Drives clock/frequency/width requests through the valid-ready input, with
// random gaps and output stalls, and compares every result beat against an
// in-order queue of typed directed values or local prescaler/period predictions.
// ----------------------------------------------------------------------------
module timer_prescaler_period_calc_top_tb;

    localparam int unsigned PSC_LIMIT = 65535;
    localparam int unsigned LATENCY   = 68;
    localparam int unsigned N_RANDOM  = 500;
    localparam longint unsigned CYCLE_LIMIT = 400000;

    typedef struct {
        logic [31:0] clk_hz;
        logic [31:0] freq_hz;
        logic        wide;
    } t_req;

    typedef struct {
        logic [15:0] psc;
        logic [31:0] period;
        logic        bad;
    } t_timing;

    typedef struct {
        t_req    req;
        bit      typed;
        t_timing want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_clock_rate_hz;
    logic [31:0] i_target_freq_hz;
    logic        i_wide_counter;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_prescale_value;
    logic [31:0] o_period_value;
    logic        o_bad_request;

    t_timing     timing_q[$];
    int          n_fail;
    bit          quiet;
    longint unsigned n_cycles;

    timer_prescaler_period_calc_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_clock_rate_hz (i_clock_rate_hz),
        .i_target_freq_hz(i_target_freq_hz),
        .i_wide_counter  (i_wide_counter),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_prescale_value(o_prescale_value),
        .o_period_value  (o_period_value),
        .o_bad_request   (o_bad_request)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic t_timing calc_timing(t_req r);
        t_timing         t;
        longint unsigned ticks;
        longint unsigned span;
        longint unsigned psc;
        longint unsigned per_p1;
        t.psc = '0;
        t.period = '0;
        t.bad = 1'b0;
        if (r.freq_hz == 0) begin
            t.bad = 1'b1;
            return t;
        end
        ticks = (longint'(r.clk_hz) + longint'(r.freq_hz >> 1)) / longint'(r.freq_hz);
        if (ticks < 2) ticks = 2;
        span = r.wide ? 64'h1_0000_0000 : 64'd65536;
        psc = (ticks > span) ? (ticks - 1) / span : 0;
        if (psc > PSC_LIMIT) psc = PSC_LIMIT;
        per_p1 = ticks / (psc + 1);
        if (per_p1 < 2) per_p1 = 2;
        t.psc = psc[15:0];
        t.period = 32'(per_p1 - 1);
        return t;
    endfunction

    function automatic t_timing mk(logic [15:0] p, logic [31:0] per, logic b);
        t_timing t;
        t.psc = p;
        t.period = per;
        t.bad = b;
        return t;
    endfunction

    function automatic t_row row(logic [31:0] c, logic [31:0] f, logic w, bit typed,
                                 t_timing want);
        t_row r;
        r.req.clk_hz = c;
        r.req.freq_hz = f;
        r.req.wide = w;
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    task automatic send(t_req r, bit typed, t_timing want);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_clock_rate_hz <= r.clk_hz;
        i_target_freq_hz <= r.freq_hz;
        i_wide_counter <= r.wide;
        timing_q.push_back(typed ? want : calc_timing(r));
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 3);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            2: return $urandom_range(0, 65535);
            3: return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_timing w;
        if (i_rst_n && o_valid && i_ready) begin
            if (timing_q.size() == 0) begin
                $error("unexpected result beat");
                n_fail++;
            end else begin
                w = timing_q.pop_front();
                if (o_prescale_value !== w.psc) begin
                    $error("prescale_value exp %0d got %0d", w.psc, o_prescale_value);
                    n_fail++;
                end
                if (o_period_value !== w.period) begin
                    $error("period_value exp %0d got %0d", w.period, o_period_value);
                    n_fail++;
                end
                if (o_bad_request !== w.bad) begin
                    $error("bad_request exp %0d got %0d", w.bad, o_bad_request);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (quiet || $urandom_range(0, 3) != 0) begin
                i_ready <= 1'b1;
            end else begin
                n = $urandom_range(1, 7);
                i_ready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("timer_prescaler_period_calc_top: mismatch");
            $finish;
        end
    end

    initial begin
        t_row    dir[$];
        t_req    r;
        t_timing none;
        n_fail = 0;
        n_cycles = 0;
        quiet = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_clock_rate_hz = '0;
        i_target_freq_hz = '0;
        i_wide_counter = 1'b0;
        none = mk(0, 0, 0);

        dir.push_back(row(32'd1000, 32'd0, 1'b0, 1, mk(0, 0, 1)));
        dir.push_back(row(32'hFFFF_FFFF, 32'd0, 1'b1, 1, mk(0, 0, 1)));
        dir.push_back(row(32'd0, 32'd1, 1'b0, 1, mk(0, 1, 0)));
        dir.push_back(row(32'd10, 32'd100, 1'b1, 1, mk(0, 1, 0)));
        dir.push_back(row(32'd5, 32'hFFFF_FFFF, 1'b0, 1, mk(0, 1, 0)));
        dir.push_back(row(32'hFFFF_FFFF, 32'd1, 1'b1, 1, mk(0, 32'hFFFF_FFFE, 0)));
        dir.push_back(row(32'hFFFF_FFFF, 32'd1, 1'b0, 1, mk(16'hFFFF, 32'd65534, 0)));
        dir.push_back(row(32'd65536, 32'd1, 1'b0, 1, mk(0, 65535, 0)));
        dir.push_back(row(32'd65537, 32'd1, 1'b0, 1, mk(1, 32767, 0)));
        dir.push_back(row(32'd72_000_000, 32'd1000, 1'b0, 0, none));
        dir.push_back(row(32'd72_000_000, 32'd1, 1'b0, 0, none));
        dir.push_back(row(32'd72_000_000, 32'd7, 1'b1, 0, none));
        dir.push_back(row(32'd100, 32'd3, 1'b0, 0, none));
        dir.push_back(row(32'd3, 32'd2, 1'b1, 0, none));
        dir.push_back(row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 0, none));
        dir.push_back(row(32'hFFFF_FFFE, 32'd2, 1'b0, 0, none));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir[k]) send(dir[k].req, dir[k].typed, dir[k].want);
        i_valid <= 1'b0;

        wait (timing_q.size() == 0);
        @(negedge i_clk);

        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == N_RANDOM - 60) quiet = 1'b1;
            r.clk_hz = rand_word();
            r.freq_hz = ($urandom_range(0, 19) == 0) ? 32'd0 : rand_word();
            r.wide = 1'($urandom_range(0, 1));
            send(r, 0, none);
        end
        i_valid <= 1'b0;

        fork
            wait (timing_q.size() == 0);
            repeat (20 * LATENCY + 2000) @(posedge i_clk);
        join_any
        disable fork;
        repeat (LATENCY + 10) @(posedge i_clk);

        if (n_fail == 0 && timing_q.size() == 0) begin
            $display("timer_prescaler_period_calc_top: match");
        end else begin
            $display("timer_prescaler_period_calc_top: mismatch");
        end
        $finish;
    end

endmodule
